@@ rtl/core/bfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burst deframer package
// Shared types, codes and constants of the burst frame deframer.
// ----------------------------------------------------------------------------
package bfd_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIM  = 1'd1;

  localparam logic [7:0] HEARTBEAT_RST = 8'd7;
  localparam logic [7:0] FRAME_LIM_RST = 8'd64;

  // Byte kinds.
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_CONTROL = 3'd1;
  localparam logic [2:0] KIND_LENGTH  = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_SKIP    = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ILLEGAL   = 3'd1;
  localparam logic [2:0] ST_NO_DATA   = 3'd2;
  localparam logic [2:0] ST_TOO_MANY  = 3'd3;
  localparam logic [2:0] ST_BAD_FIELD = 3'd4;
  localparam logic [2:0] ST_HEARTBEAT = 3'd5;

  // Header field limits.
  localparam logic [3:0] MODE_MAX   = 4'h3;
  localparam logic [7:0] METHOD_MAX = 8'h09;
  localparam logic [2:0] SYNC_LEN   = 3'd6;

  // Parser phases, one-hot.
  typedef enum logic [8:0] {
    PH_MAGIC  = 9'b000000001,
    PH_VER    = 9'b000000010,
    PH_CE     = 9'b000000100,
    PH_METHOD = 9'b000001000,
    PH_COUNT  = 9'b000010000,
    PH_SKIP   = 9'b000100000,
    PH_CTRL   = 9'b001000000,
    PH_LEN    = 9'b010000000,
    PH_PAY    = 9'b100000000
  } phase_t;

  // Configuration seen by the parser.
  typedef struct packed {
    logic [7:0] heartbeat_code;
    logic [7:0] frame_limit;
  } bfd_cfg_t;

  // One tagged result beat.
  typedef struct packed {
    logic [2:0] byte_kind;
    logic [7:0] payload_byte;
    logic       frame_last;
    logic       package_last;
    logic       request_last;
    logic [2:0] status;
    logic [7:0] frame_number;
    logic [7:0] package_number;
    logic [7:0] method_code;
    logic [3:0] compress_mode;
    logic [3:0] encrypt_mode;
    logic [7:0] version_byte;
  } bfd_res_t;

  // Sync pattern that opens every burst header.
  function automatic logic [7:0] sync_byte(input logic [2:0] pos);
    logic [7:0] val;
    unique case (pos)
      3'd0:    val = 8'h23;
      3'd1:    val = 8'h4D;
      3'd2:    val = 8'h46;
      3'd3:    val = 8'h50;
      3'd4:    val = 8'h54;
      3'd5:    val = 8'h50;
      default: val = 8'h23;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/core/bfd_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burst deframer parser
// Holds the burst parse state and tags one byte per step.
// ----------------------------------------------------------------------------
module bfd_parse import bfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  bfd_cfg_t   cfg,
  output bfd_res_t   res
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  header_pos_r, header_pos_nxt;
  logic [7:0]  hdr_version_r, hdr_version_nxt;
  logic [7:0]  hdr_comp_enc_r, hdr_comp_enc_nxt;
  logic [7:0]  hdr_method_r, hdr_method_nxt;
  logic [7:0]  package_total_r, package_total_nxt;
  logic [7:0]  packages_done_r, packages_done_nxt;
  logic [7:0]  frames_r, frames_nxt;
  logic [2:0]  len_left_r, len_left_nxt;
  logic [31:0] frame_length_r, frame_length_nxt;
  logic [31:0] payload_left_r, payload_left_nxt;
  logic        package_more_r, package_more_nxt;
  logic        frame_over_r, frame_over_nxt;

  logic        frame_end;
  logic        clear_frames;
  logic        restart;
  logic [2:0]  sync_pos;
  logic [2:0]  sync_pos_inc;
  logic [31:0] shifted_len;
  logic [2:0]  kind;
  logic [2:0]  status;
  logic        frame_last;
  logic        package_last;
  logic        request_last;

  // Next-state and tag logic for the byte in hand.
  always_comb begin
    phase_nxt         = phase_r;
    header_pos_nxt    = header_pos_r;
    hdr_version_nxt   = hdr_version_r;
    hdr_comp_enc_nxt  = hdr_comp_enc_r;
    hdr_method_nxt    = hdr_method_r;
    package_total_nxt = package_total_r;
    packages_done_nxt = packages_done_r;
    frames_nxt        = frames_r;
    len_left_nxt      = len_left_r;
    frame_length_nxt  = frame_length_r;
    payload_left_nxt  = payload_left_r;
    package_more_nxt  = package_more_r;
    frame_over_nxt    = frame_over_r;
    kind              = KIND_HEADER;
    status            = ST_OK;
    frame_last        = 1'b0;
    package_last      = 1'b0;
    request_last      = 1'b0;
    frame_end         = 1'b0;
    clear_frames      = 1'b0;
    restart           = 1'b0;
    sync_pos          = (header_pos_r > 3'd5) ? 3'd0 : header_pos_r;
    sync_pos_inc      = sync_pos + 3'd1;
    shifted_len       = {frame_length_r[23:0], rx_byte};

    unique case (phase_r)
      PH_VER: begin
        hdr_version_nxt = rx_byte;
        phase_nxt       = PH_CE;
      end
      PH_CE: begin
        hdr_comp_enc_nxt = rx_byte;
        phase_nxt        = PH_METHOD;
      end
      PH_METHOD: begin
        hdr_method_nxt = rx_byte;
        if (hdr_comp_enc_r[7:4] > MODE_MAX || hdr_comp_enc_r[3:0] > MODE_MAX ||
            rx_byte > METHOD_MAX) begin
          status = ST_BAD_FIELD;
        end
        phase_nxt = (rx_byte == cfg.heartbeat_code) ? PH_SKIP : PH_COUNT;
      end
      PH_SKIP: begin
        kind         = KIND_SKIP;
        status       = ST_HEARTBEAT;
        request_last = 1'b1;
        restart      = 1'b1;
      end
      PH_COUNT: begin
        package_total_nxt = rx_byte;
        if (rx_byte == 8'd0) begin
          status       = ST_NO_DATA;
          request_last = 1'b1;
          restart      = 1'b1;
        end else begin
          packages_done_nxt = 8'd0;
          frames_nxt        = 8'd0;
          phase_nxt         = PH_CTRL;
        end
      end
      PH_CTRL: begin
        kind = KIND_CONTROL;
        if (rx_byte[3]) begin
          status       = ST_ILLEGAL;
          request_last = 1'b1;
          restart      = 1'b1;
        end else begin
          package_more_nxt = rx_byte[2];
          len_left_nxt     = {1'b0, rx_byte[1:0]} + 3'd1;
          frame_length_nxt = 32'd0;
          if (frames_r >= cfg.frame_limit) begin
            frame_over_nxt = 1'b1;
          end else begin
            frames_nxt = frames_r + 8'd1;
          end
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        kind             = KIND_LENGTH;
        frame_length_nxt = shifted_len;
        if (len_left_r != 3'd0) begin
          len_left_nxt = len_left_r - 3'd1;
        end
        if (len_left_nxt == 3'd0) begin
          if (shifted_len == 32'd0) begin
            frame_end = 1'b1;
          end else begin
            payload_left_nxt = shifted_len;
            phase_nxt        = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        kind = KIND_PAYLOAD;
        if (payload_left_r != 32'd0) begin
          payload_left_nxt = payload_left_r - 32'd1;
        end
        if (payload_left_nxt == 32'd0) begin
          frame_end = 1'b1;
        end
      end
      default: begin
        // Hunting for the sync pattern.
        if (rx_byte == sync_byte(sync_pos)) begin
          if (sync_pos_inc == SYNC_LEN) begin
            header_pos_nxt = 3'd0;
            phase_nxt      = PH_VER;
          end else begin
            header_pos_nxt = sync_pos_inc;
          end
        end else begin
          status       = ST_ILLEGAL;
          request_last = 1'b1;
          restart      = 1'b1;
        end
      end
    endcase

    // Frame completion: limit check, package and request accounting.
    if (frame_end) begin
      frame_last = 1'b1;
      if (frame_over_r) begin
        status       = ST_TOO_MANY;
        request_last = 1'b1;
        restart      = 1'b1;
      end else if (!package_more_r) begin
        package_last      = 1'b1;
        packages_done_nxt = packages_done_r + 8'd1;
        if (packages_done_nxt >= package_total_r) begin
          request_last = 1'b1;
          restart      = 1'b1;
        end else begin
          clear_frames = 1'b1;
          phase_nxt    = PH_CTRL;
        end
      end else begin
        phase_nxt = PH_CTRL;
      end
    end

    if (restart) begin
      phase_nxt      = PH_MAGIC;
      header_pos_nxt = 3'd0;
      frame_over_nxt = 1'b0;
    end

    // The frame number reports the count before an end-of-package clear.
    res.byte_kind      = kind;
    res.payload_byte   = (kind == KIND_PAYLOAD) ? rx_byte : 8'd0;
    res.frame_last     = frame_last;
    res.package_last   = package_last;
    res.request_last   = request_last;
    res.status         = status;
    res.frame_number   = frames_nxt;
    res.package_number = packages_done_nxt;
    res.method_code    = hdr_method_nxt;
    res.compress_mode  = hdr_comp_enc_nxt[7:4];
    res.encrypt_mode   = hdr_comp_enc_nxt[3:0];
    res.version_byte   = hdr_version_nxt;

    if (clear_frames) begin
      frames_nxt = 8'd0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_MAGIC;
      header_pos_r    <= 3'd0;
      hdr_version_r   <= 8'd0;
      hdr_comp_enc_r  <= 8'd0;
      hdr_method_r    <= 8'd0;
      package_total_r <= 8'd0;
      packages_done_r <= 8'd0;
      frames_r        <= 8'd0;
      len_left_r      <= 3'd0;
      frame_length_r  <= 32'd0;
      payload_left_r  <= 32'd0;
      package_more_r  <= 1'b0;
      frame_over_r    <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      header_pos_r    <= header_pos_nxt;
      hdr_version_r   <= hdr_version_nxt;
      hdr_comp_enc_r  <= hdr_comp_enc_nxt;
      hdr_method_r    <= hdr_method_nxt;
      package_total_r <= package_total_nxt;
      packages_done_r <= packages_done_nxt;
      frames_r        <= frames_nxt;
      len_left_r      <= len_left_nxt;
      frame_length_r  <= frame_length_nxt;
      payload_left_r  <= payload_left_nxt;
      package_more_r  <= package_more_nxt;
      frame_over_r    <= frame_over_nxt;
    end
  end

endmodule

@@ rtl/core/burst_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burst frame deframer
// Tags each received byte of a burst and marks frame, package and request
// ends. A byte waits in the input register, is tagged by the combinational parse
// step and lands in the result register. Throughput: one byte per cycle, set by
// the parse step between the two registers; a stalled result holds the input.
// Reset is synchronous: it empties both registers, returns the parser to sync
// hunting with cleared counters and header values, and loads the register
// defaults.
// ----------------------------------------------------------------------------
module burst_frame_deframer import bfd_pkg::*; #(
  parameter int MAX_FRAMES = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Byte input.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  // Tagged result output.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_byte_kind,
  output logic [7:0]           out_payload_byte,
  output logic                 out_frame_last,
  output logic                 out_package_last,
  output logic                 out_request_last,
  output logic [2:0]           out_status,
  output logic [7:0]           out_frame_number,
  output logic [7:0]           out_package_number,
  output logic [7:0]           out_method_code,
  output logic [3:0]           out_compress_mode,
  output logic [3:0]           out_encrypt_mode,
  output logic [7:0]           out_version_byte,
  // Register writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam logic [7:0] MAX_FRAMES_C = 8'(MAX_FRAMES);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  bfd_res_t   res_r;
  bfd_res_t   res_comb;
  logic [7:0] heartbeat_r;
  logic [7:0] frame_lim_r;
  bfd_cfg_t   cfg;
  logic       advance;
  logic       in_take;

  // Register port: always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heartbeat_r <= HEARTBEAT_RST;
      frame_lim_r <= FRAME_LIM_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HEARTBEAT) begin
        heartbeat_r <= cfg_data;
      end
      if (cfg_index == CFG_FRAME_LIM) begin
        frame_lim_r <= cfg_data;
      end
    end
  end

  // Limit in force is the smaller of the register and the build maximum.
  assign cfg.heartbeat_code = heartbeat_r;
  assign cfg.frame_limit    = (frame_lim_r < MAX_FRAMES_C) ? frame_lim_r : MAX_FRAMES_C;

  // Pipeline flow control: the parse step fires when the result slot frees.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input and result data registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance) begin
      res_r <= res_comb;
    end
  end

  bfd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res_comb)
  );

  // Result beat outputs.
  assign out_valid          = out_valid_r;
  assign out_byte_kind      = res_r.byte_kind;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_frame_last     = res_r.frame_last;
  assign out_package_last   = res_r.package_last;
  assign out_request_last   = res_r.request_last;
  assign out_status         = res_r.status;
  assign out_frame_number   = res_r.frame_number;
  assign out_package_number = res_r.package_number;
  assign out_method_code    = res_r.method_code;
  assign out_compress_mode  = res_r.compress_mode;
  assign out_encrypt_mode   = res_r.encrypt_mode;
  assign out_version_byte   = res_r.version_byte;

  // A heartbeat always ends the request on a skipped byte.
  a_heartbeat_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_HEARTBEAT |-> out_request_last &&
      out_byte_kind == KIND_SKIP)
    else $error("heartbeat result without request end");

  // A package can only end on the last byte of a frame.
  a_package_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_package_last |-> out_frame_last)
    else $error("package end without frame end");

  // Frame overrun closes the request on a frame end, never a package end.
  a_too_many: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TOO_MANY |-> out_frame_last && out_request_last &&
      !out_package_last)
    else $error("bad frame overrun tagging");

  // A full pipeline with a blocked output must hold off the input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && out_stall |-> in_stall)
    else $error("input taken while pipeline blocked");

endmodule
